[rtl/pidaw_pkg.sv]
// ----------------------------------------------------------------------------
// pidaw_pkg
// Shared types, constants and saturating helpers for the PID controller
// with integral anti-windup.
// ----------------------------------------------------------------------------
package pidaw_pkg;

  localparam int DataW   = 32;               // signed Q16.16 data
  localparam int FracW   = 16;               // fraction bits
  localparam int TimeW   = 24;               // unsigned Q8.16 time
  localparam int LimW    = DataW - 1;        // limit register width
  localparam int BusW    = 32;               // config bus data width
  localparam int AddrW   = 5;                // byte address, six registers
  localparam int DivW    = DataW + FracW;    // divider dividend/quotient width
  localparam int ProdW   = 2 * DataW;        // full product width
  localparam int QW      = ProdW - FracW;    // product after fraction drop

  localparam logic [TimeW-1:0] StepFloorRst = TimeW'(66);

  localparam logic signed [DataW-1:0] MaxVal = {1'b0, {(DataW-1){1'b1}}};
  localparam logic signed [DataW-1:0] MinVal = {1'b1, {(DataW-1){1'b0}}};

  typedef enum logic [2:0] {
    REG_GAIN_PROP   = 3'd0,
    REG_GAIN_INTEG  = 3'd1,
    REG_GAIN_DERIV  = 3'd2,
    REG_INTEG_LIMIT = 3'd3,
    REG_DRIVE_LIMIT = 3'd4,
    REG_STEP_FLOOR  = 3'd5
  } reg_idx_e;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_ERR,
    OP_DIFF,
    OP_DIV_STEP,
    OP_DIV_END,
    OP_DRV_LOAD,
    OP_DRV_ADD,
    OP_CAND,
    OP_COMMIT,
    OP_PUSH
  } dp_op_e;

  typedef enum logic [2:0] {
    MS_ERR_KP,
    MS_DER_KD,
    MS_ERR_DT,
    MS_CAND_KI,
    MS_INT_KI
  } mul_sel_e;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_ERR,
    ST_DIFF,
    ST_DIV,
    ST_DIV_END,
    ST_MUL_P,
    ST_MUL_D,
    ST_P_LOAD,
    ST_D_ADD,
    ST_MUL_DT,
    ST_WAIT_DT,
    ST_CAND,
    ST_MUL_CAND,
    ST_WAIT_CAND,
    ST_COMMIT,
    ST_MUL_ACC,
    ST_WAIT_ACC,
    ST_I_ADD,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic signed [DataW-1:0] gain_prop;
    logic signed [DataW-1:0] gain_integ;
    logic signed [DataW-1:0] gain_deriv;
    logic [LimW-1:0]         integ_limit;
    logic [LimW-1:0]         drive_limit;
    logic [TimeW-1:0]        step_floor;
  } cfg_t;

  typedef struct packed {
    dp_op_e   op;
    mul_sel_e msel;
  } cmd_t;

  typedef struct packed {
    logic ki_pos;
    logic out_free;
  } status_t;

  // saturate a sum that grew by one bit
  function automatic logic signed [DataW-1:0] sat_wide(input logic [DataW:0] s);
    logic signed [DataW-1:0] r;
    if (s[DataW] != s[DataW-1]) begin
      r = s[DataW] ? MinVal : MaxVal;
    end else begin
      r = s[DataW-1:0];
    end
    return r;
  endfunction

  function automatic logic signed [DataW-1:0] sat_add(input logic signed [DataW-1:0] a,
                                                       input logic signed [DataW-1:0] b);
    logic [DataW:0] s;
    s = {a[DataW-1], a} + {b[DataW-1], b};
    return sat_wide(s);
  endfunction

  function automatic logic signed [DataW-1:0] sat_sub(input logic signed [DataW-1:0] a,
                                                       input logic signed [DataW-1:0] b);
    logic [DataW:0] s;
    s = {a[DataW-1], a} - {b[DataW-1], b};
    return sat_wide(s);
  endfunction

  // magnitude; the most negative value maps to 2^(W-1)
  function automatic logic [DataW-1:0] mag(input logic signed [DataW-1:0] a);
    logic [DataW-1:0] u;
    u = a;
    return u[DataW-1] ? (~u + 1'b1) : u;
  endfunction

endpackage

[rtl/pidaw_ifs.sv]
// ----------------------------------------------------------------------------
// pidaw_ifs
// Stream interfaces for sample words in and drive words out.
// ----------------------------------------------------------------------------
interface pidaw_in_if;
  import pidaw_pkg::*;

  logic                    valid;
  logic                    ready;
  logic signed [DataW-1:0] setpoint;
  logic signed [DataW-1:0] measured;
  logic [TimeW-1:0]        time_step;
  logic                    clear_integ;

  modport source (output valid, setpoint, measured, time_step, clear_integ, input ready);
  modport sink   (input valid, setpoint, measured, time_step, clear_integ, output ready);
endinterface

interface pidaw_out_if;
  import pidaw_pkg::*;

  logic                    valid;
  logic                    ready;
  logic signed [DataW-1:0] drive;

  modport source (output valid, drive, input ready);
  modport sink   (input valid, drive, output ready);
endinterface

[rtl/pidaw_regs.sv]
// ----------------------------------------------------------------------------
// pidaw_regs
// APB configuration registers: gains, limits and minimum time step.
// ----------------------------------------------------------------------------
module pidaw_regs (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [pidaw_pkg::AddrW-1:0]   paddr,
  input  logic [pidaw_pkg::BusW-1:0]    pwdata,
  output logic [pidaw_pkg::BusW-1:0]    prdata,
  output logic                          pready,
  output pidaw_pkg::cfg_t               cfg_o
);
  import pidaw_pkg::*;

  cfg_t     cfg_q, cfg_d;
  reg_idx_e idx;
  logic     wr_en;

  assign idx    = reg_idx_e'(paddr[AddrW-1:2]);
  assign wr_en  = psel & penable & pwrite;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (idx)
        REG_GAIN_PROP:   cfg_d.gain_prop   = pwdata[DataW-1:0];
        REG_GAIN_INTEG:  cfg_d.gain_integ  = pwdata[DataW-1:0];
        REG_GAIN_DERIV:  cfg_d.gain_deriv  = pwdata[DataW-1:0];
        REG_INTEG_LIMIT: cfg_d.integ_limit = pwdata[LimW-1:0];
        REG_DRIVE_LIMIT: cfg_d.drive_limit = pwdata[LimW-1:0];
        REG_STEP_FLOOR:  cfg_d.step_floor  = pwdata[TimeW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_GAIN_PROP:   prdata = BusW'(unsigned'(cfg_q.gain_prop));
      REG_GAIN_INTEG:  prdata = BusW'(unsigned'(cfg_q.gain_integ));
      REG_GAIN_DERIV:  prdata = BusW'(unsigned'(cfg_q.gain_deriv));
      REG_INTEG_LIMIT: prdata = BusW'(cfg_q.integ_limit);
      REG_DRIVE_LIMIT: prdata = BusW'(cfg_q.drive_limit);
      REG_STEP_FLOOR:  prdata = BusW'(cfg_q.step_floor);
      default:         prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.gain_prop   <= '0;
      cfg_q.gain_integ  <= '0;
      cfg_q.gain_deriv  <= '0;
      cfg_q.integ_limit <= '0;
      cfg_q.drive_limit <= '0;
      cfg_q.step_floor  <= StepFloorRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

[rtl/pidaw_ctrl.sv]
// ----------------------------------------------------------------------------
// pidaw_ctrl
// Sequencer: walks the datapath through error, divide, multiply-accumulate
// and integral commit for one sample word.
// ----------------------------------------------------------------------------
module pidaw_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  pidaw_pkg::status_t   status_i,
  output pidaw_pkg::cmd_t      cmd_o
);
  import pidaw_pkg::*;

  localparam int DivSteps = DivW;
  localparam int CntW     = $clog2(DivSteps);

  state_e          state_q, state_d;
  logic [CntW-1:0] cnt_q, cnt_d;

  // next state
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    case (state_q)
      ST_IDLE:      if (in_valid_i) state_d = ST_ERR;
      ST_ERR:       state_d = ST_DIFF;
      ST_DIFF: begin
        state_d = ST_DIV;
        cnt_d   = '0;
      end
      ST_DIV: begin
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == CntW'(DivSteps - 1)) state_d = ST_DIV_END;
      end
      ST_DIV_END:   state_d = ST_MUL_P;
      ST_MUL_P:     state_d = ST_MUL_D;
      ST_MUL_D:     state_d = ST_P_LOAD;
      ST_P_LOAD:    state_d = ST_D_ADD;
      ST_D_ADD:     state_d = status_i.ki_pos ? ST_MUL_DT : ST_DONE;
      ST_MUL_DT:    state_d = ST_WAIT_DT;
      ST_WAIT_DT:   state_d = ST_CAND;
      ST_CAND:      state_d = ST_MUL_CAND;
      ST_MUL_CAND:  state_d = ST_WAIT_CAND;
      ST_WAIT_CAND: state_d = ST_COMMIT;
      ST_COMMIT:    state_d = ST_MUL_ACC;
      ST_MUL_ACC:   state_d = ST_WAIT_ACC;
      ST_WAIT_ACC:  state_d = ST_I_ADD;
      ST_I_ADD:     state_d = ST_DONE;
      ST_DONE:      if (status_i.out_free) state_d = ST_IDLE;
      default:      state_d = ST_IDLE;
    endcase
  end

  // outputs; the multiplier has two register stages, so a product issued
  // in one state is consumed once it has passed through prod_q and mres_q
  always_comb begin
    cmd_o.op   = OP_NONE;
    cmd_o.msel = MS_ERR_KP;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) cmd_o.op = OP_LOAD;
      end
      ST_ERR:       cmd_o.op = OP_ERR;
      ST_DIFF:      cmd_o.op = OP_DIFF;
      ST_DIV:       cmd_o.op = OP_DIV_STEP;
      ST_DIV_END:   cmd_o.op = OP_DIV_END;
      ST_MUL_P:     cmd_o.msel = MS_ERR_KP;
      ST_MUL_D:     cmd_o.msel = MS_DER_KD;
      ST_P_LOAD:    cmd_o.op = OP_DRV_LOAD;
      ST_D_ADD:     cmd_o.op = OP_DRV_ADD;
      ST_MUL_DT:    cmd_o.msel = MS_ERR_DT;
      ST_WAIT_DT:   cmd_o.op = OP_NONE;
      ST_CAND:      cmd_o.op = OP_CAND;
      ST_MUL_CAND:  cmd_o.msel = MS_CAND_KI;
      ST_WAIT_CAND: cmd_o.op = OP_NONE;
      ST_COMMIT:    cmd_o.op = OP_COMMIT;
      ST_MUL_ACC:   cmd_o.msel = MS_INT_KI;
      ST_WAIT_ACC:  cmd_o.op = OP_NONE;
      ST_I_ADD:     cmd_o.op = OP_DRV_ADD;
      ST_DONE:      if (status_i.out_free) cmd_o.op = OP_PUSH;
      default:      cmd_o.op = OP_NONE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

endmodule

[rtl/pidaw_dp.sv]
// ----------------------------------------------------------------------------
// pidaw_dp
// Datapath: saturating add/sub, restoring divider, shared two-stage
// multiplier, integral state and output word register.
// ----------------------------------------------------------------------------
module pidaw_dp (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  pidaw_pkg::cfg_t                      cfg_i,
  input  pidaw_pkg::cmd_t                      cmd_i,
  output pidaw_pkg::status_t                   status_o,
  input  logic signed [pidaw_pkg::DataW-1:0]   setpoint_i,
  input  logic signed [pidaw_pkg::DataW-1:0]   measured_i,
  input  logic [pidaw_pkg::TimeW-1:0]          time_step_i,
  input  logic                                 clear_integ_i,
  input  logic                                 out_ready_i,
  output logic                                 out_valid_o,
  output logic signed [pidaw_pkg::DataW-1:0]   drive_o
);
  import pidaw_pkg::*;

  // sample and working registers
  logic signed [DataW-1:0] sp_q, pv_q, err_q, deriv_q, cand_q, drive_q;
  logic [TimeW-1:0]        dt_q, den_q;
  logic signed [DataW-1:0] integ_q, prev_q;
  logic                    out_valid_q;
  logic signed [DataW-1:0] out_q;

  // divider
  logic [DivW-1:0]         num_q, quo_q;
  logic [TimeW-1:0]        rem_q;
  logic                    dneg_q;

  // multiplier
  logic signed [DataW-1:0] ma, mb;
  logic                    mb_neg;
  logic [ProdW-1:0]        prod_q;
  logic                    pneg_q;
  logic signed [DataW-1:0] mres_q;

  // ---- combinational helpers ----
  logic [TimeW-1:0]        den_d;
  logic signed [DataW-1:0] dd;
  logic [TimeW:0]          r2, r2_sub;
  logic                    r_ge;
  logic [DivW-1:0]         dlim;
  logic [DataW-1:0]        dq_mag;
  logic [QW-1:0]           psh, plim;
  logic [DataW-1:0]        pm;
  logic signed [DataW-1:0] drv_try, clamp_val, dl_s, il_s;
  logic                    commit_ok;

  always_comb begin
    den_d = (dt_q > cfg_i.step_floor) ? dt_q : cfg_i.step_floor;
    if (den_d == '0) den_d = TimeW'(1);
  end

  assign dd = sat_sub(err_q, prev_q);

  // one restoring step per cycle
  assign r2     = {rem_q, num_q[DivW-1]};
  assign r2_sub = r2 - {1'b0, den_q};
  assign r_ge   = r2 >= {1'b0, den_q};

  // quotient clamp: 2^(W-1) for negative, 2^(W-1)-1 for positive
  assign dlim   = {{(DivW-DataW){1'b0}}, dneg_q, {(DataW-1){~dneg_q}}};
  assign dq_mag = (quo_q > dlim) ? dlim[DataW-1:0] : quo_q[DataW-1:0];

  always_comb begin
    ma     = err_q;
    mb     = cfg_i.gain_prop;
    mb_neg = cfg_i.gain_prop[DataW-1];
    case (cmd_i.msel)
      MS_ERR_KP: begin
        ma     = err_q;
        mb     = cfg_i.gain_prop;
        mb_neg = cfg_i.gain_prop[DataW-1];
      end
      MS_DER_KD: begin
        ma     = deriv_q;
        mb     = cfg_i.gain_deriv;
        mb_neg = cfg_i.gain_deriv[DataW-1];
      end
      MS_ERR_DT: begin
        ma     = err_q;
        mb     = DataW'(dt_q);
        mb_neg = 1'b0;
      end
      MS_CAND_KI: begin
        ma     = cand_q;
        mb     = cfg_i.gain_integ;
        mb_neg = cfg_i.gain_integ[DataW-1];
      end
      MS_INT_KI: begin
        ma     = integ_q;
        mb     = cfg_i.gain_integ;
        mb_neg = cfg_i.gain_integ[DataW-1];
      end
      default: ;
    endcase
  end

  // product >> FracW, magnitude truncated, then clamped to the signed range
  assign psh  = prod_q[ProdW-1:FracW];
  assign plim = {{(QW-DataW){1'b0}}, pneg_q, {(DataW-1){~pneg_q}}};
  assign pm   = (psh > plim) ? plim[DataW-1:0] : psh[DataW-1:0];

  assign dl_s = {1'b0, cfg_i.drive_limit};
  assign il_s = {1'b0, cfg_i.integ_limit};

  assign drv_try   = sat_add(drive_q, mres_q);
  assign commit_ok = ((cfg_i.drive_limit == '0) || (mag(drv_try) <= unsigned'(dl_s)))
                     && (mag(cand_q) <= unsigned'(il_s));

  always_comb begin
    clamp_val = drive_q;
    if (cfg_i.drive_limit != '0) begin
      if (drive_q > dl_s) begin
        clamp_val = dl_s;
      end else if (drive_q < -dl_s) begin
        clamp_val = -dl_s;
      end
    end
  end

  assign status_o.ki_pos   = !cfg_i.gain_integ[DataW-1] && (cfg_i.gain_integ != '0);
  assign status_o.out_free = !out_valid_q || out_ready_i;
  assign out_valid_o       = out_valid_q;
  assign drive_o           = out_q;

  // ---- state with reset ----
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      integ_q     <= '0;
      prev_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.op == OP_LOAD && clear_integ_i) integ_q <= '0;
      if (cmd_i.op == OP_COMMIT && commit_ok)  integ_q <= cand_q;
      if (cmd_i.op == OP_DIFF)                 prev_q  <= err_q;
      if (cmd_i.op == OP_PUSH) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // ---- payload registers ----
  always_ff @(posedge clk_i) begin
    prod_q <= ProdW'(mag(ma)) * ProdW'(mag(mb));
    pneg_q <= ma[DataW-1] ^ mb_neg;
    mres_q <= pneg_q ? signed'(~pm + 1'b1) : signed'(pm);

    case (cmd_i.op)
      OP_LOAD: begin
        sp_q <= setpoint_i;
        pv_q <= measured_i;
        dt_q <= time_step_i;
      end
      OP_ERR: begin
        err_q <= sat_sub(sp_q, pv_q);
        den_q <= den_d;
      end
      OP_DIFF: begin
        num_q  <= {mag(dd), {FracW{1'b0}}};
        rem_q  <= '0;
        quo_q  <= '0;
        dneg_q <= dd[DataW-1];
      end
      OP_DIV_STEP: begin
        num_q <= {num_q[DivW-2:0], 1'b0};
        quo_q <= {quo_q[DivW-2:0], r_ge};
        rem_q <= r_ge ? r2_sub[TimeW-1:0] : r2[TimeW-1:0];
      end
      OP_DIV_END:  deriv_q <= dneg_q ? signed'(~dq_mag + 1'b1) : signed'(dq_mag);
      OP_DRV_LOAD: drive_q <= mres_q;
      OP_DRV_ADD:  drive_q <= sat_add(drive_q, mres_q);
      OP_CAND:     cand_q  <= sat_add(integ_q, mres_q);
      OP_PUSH:     out_q   <= clamp_val;
      default: ;
    endcase
  end

endmodule

[rtl/pid_controller_antiwindup.sv]
// ----------------------------------------------------------------------------
// pid_controller_antiwindup
// PID controller with integral anti-windup, signed Q16.16 fixed point.
// ----------------------------------------------------------------------------
// One sample word in (setpoint, measured, time step, clear flag) gives one
// drive word out. A word is taken only while the sequencer is idle; the
// integral steps run only when gain_integ is positive, and the sequencer
// returns to idle as it loads the drive word into the output register, so a
// new word is taken only once the last one is finished. The pass length is
// set by the 48-step restoring divider for the derivative (one quotient bit
// per cycle) and by the single shared 32x32 multiplier, which has two
// register stages. The output register holds a finished drive word while the
// next sample is already being worked on; a word still waiting there stalls
// the sequencer at its last step. Registers sit at byte addresses 4*i on the
// APB port; write them only while the block is idle.
// ----------------------------------------------------------------------------
module pid_controller_antiwindup (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  pidaw_in_if.sink                      in_ch_i,
  pidaw_out_if.source                   out_ch_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [pidaw_pkg::AddrW-1:0]   paddr,
  input  logic [pidaw_pkg::BusW-1:0]    pwdata,
  output logic [pidaw_pkg::BusW-1:0]    prdata,
  output logic                          pready
);
  import pidaw_pkg::*;

  cfg_t    cfg;
  cmd_t    cmd;
  status_t status;
  logic    in_ready;

  assign in_ch_i.ready = in_ready;

  pidaw_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  pidaw_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_ch_i.valid),
    .in_ready_o (in_ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  pidaw_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg),
    .cmd_i         (cmd),
    .status_o      (status),
    .setpoint_i    (in_ch_i.setpoint),
    .measured_i    (in_ch_i.measured),
    .time_step_i   (in_ch_i.time_step),
    .clear_integ_i (in_ch_i.clear_integ),
    .out_ready_i   (out_ch_o.ready),
    .out_valid_o   (out_ch_o.valid),
    .drive_o       (out_ch_o.drive)
  );

endmodule

[verif/tb.sv]
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the PID controller with integral anti-windup.
// A short table of directed sample words runs first, then random register
// settings, each with a mix of steady control sequences and raw noise words.
// Drive words must match a bit-exact Q16.16 predictor or a known row's value.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import pidaw_pkg::*;

  localparam int NumRows    = 25;
  localparam int NumPhases  = 12;
  localparam int PhaseItems = 160;
  localparam int SettleCyc  = 80;   // covers the longest sequencer pass
  localparam int IdleCyc    = 4;

  // indexes past the register map; writes there must be dropped
  localparam logic [2:0] RegSpareLo = 3'd6;
  localparam logic [2:0] RegSpareHi = 3'd7;

  typedef struct packed {
    logic signed [DataW-1:0] setpoint;
    logic signed [DataW-1:0] measured;
    logic [TimeW-1:0]        time_step;
    logic                    clear_integ;
  } sample_t;

  typedef struct packed {
    logic [2:0]              cfg_sel;
    logic                    known;
    logic signed [DataW-1:0] drive;
    sample_t                 smp;
  } dir_row_t;

  // setting 0 is the reset state and is never written
  localparam cfg_t DirCfgs [8] = '{
    '{32'sh0, 32'sh0, 32'sh0, 31'h0, 31'h0, 24'd66},
    '{32'sh0001_0000, 32'sh0, 32'sh0, 31'h0, 31'h0, 24'd66},
    '{32'sh0001_0000, 32'sh0, 32'sh0, 31'h0, 31'h0005_0000, 24'd66},
    '{32'sh0, 32'sh0, 32'sh0001_0000, 31'h0, 31'h0, 24'd0},
    '{32'sh0000_8000, 32'sh1, 32'sh0, 31'h7FFF_FFFF, 31'h0, 24'd1},
    '{32'sh0001_0000, 32'sh0001_0000, 32'sh0000_0100, 31'h0002_0000, 31'h0003_0000,
      24'hFF_FFFF},
    '{MinVal, MaxVal, MinVal, 31'h7FFF_FFFF, 31'h7FFF_FFFF, 24'hFF_FFFF},
    '{MaxVal, MinVal, MaxVal, 31'h0, 31'h1, 24'd66}
  };

  localparam dir_row_t DirRows [NumRows] = '{
    // reset gains: drive is zero whatever comes in
    '{3'd0, 1'b1, 32'sh0, '{MaxVal, MinVal, 24'hFF_FFFF, 1'b0}},
    '{3'd0, 1'b1, 32'sh0, '{MinVal, MaxVal, 24'h00_0000, 1'b1}},
    '{3'd0, 1'b1, 32'sh0, '{32'sh0, 32'sh0, 24'h00_0000, 1'b0}},
    // unity kp: saturated error passes straight through
    '{3'd1, 1'b1, MaxVal, '{MaxVal, MinVal, 24'hFF_FFFF, 1'b0}},
    '{3'd1, 1'b1, MinVal, '{MinVal, MaxVal, 24'h00_0000, 1'b0}},
    '{3'd1, 1'b1, 32'sh0002_0000, '{32'sh0003_0000, 32'sh0001_0000, 24'd66, 1'b1}},
    // unity kp with a 5.0 clamp
    '{3'd2, 1'b1, 32'sh0005_0000, '{32'sh000A_0000, 32'sh0, 24'd66, 1'b0}},
    '{3'd2, 1'b1, 32'shFFFB_0000, '{32'sh0, 32'sh000A_0000, 24'd66, 1'b0}},
    '{3'd2, 1'b1, 32'sh0002_0000, '{32'sh0002_0000, 32'sh0, 24'd66, 1'b0}},
    // zero floor: a zero time step makes the divisor fall back to one LSB
    '{3'd3, 1'b0, 32'sh0, '{32'sh0000_0100, 32'sh0, 24'd0, 1'b0}},
    '{3'd3, 1'b0, 32'sh0, '{32'sh0, 32'sh0, 24'd0, 1'b0}},
    '{3'd3, 1'b0, 32'sh0, '{MaxVal, 32'sh0, 24'd1, 1'b0}},
    // ki of one LSB still counts as positive
    '{3'd4, 1'b0, 32'sh0, '{32'sh0001_0000, 32'sh0, 24'h00_0100, 1'b0}},
    '{3'd4, 1'b0, 32'sh0, '{32'sh0001_0000, 32'sh0, 24'h00_0100, 1'b0}},
    '{3'd4, 1'b0, 32'sh0, '{MinVal, 32'sh0, 24'hFF_FFFF, 1'b1}},
    // anti-windup: candidates checked against both limits
    '{3'd5, 1'b0, 32'sh0, '{32'sh0004_0000, 32'sh0, 24'h01_0000, 1'b0}},
    '{3'd5, 1'b0, 32'sh0, '{32'sh0004_0000, 32'sh0, 24'h01_0000, 1'b0}},
    '{3'd5, 1'b0, 32'sh0, '{32'shFFFC_0000, 32'sh0, 24'h00_8000, 1'b0}},
    '{3'd5, 1'b0, 32'sh0, '{32'sh0001_0000, 32'sh0000_8000, 24'd66, 1'b1}},
    // extreme gains and limits
    '{3'd6, 1'b0, 32'sh0, '{MaxVal, MinVal, 24'hFF_FFFF, 1'b0}},
    '{3'd6, 1'b0, 32'sh0, '{MinVal, MaxVal, 24'hFF_FFFF, 1'b1}},
    '{3'd6, 1'b0, 32'sh0, '{32'sh0, MaxVal, 24'd0, 1'b0}},
    '{3'd7, 1'b0, 32'sh0, '{32'sh1, 32'sh0, 24'd66, 1'b0}},
    '{3'd7, 1'b0, 32'sh0, '{MinVal, MaxVal, 24'hFF_FFFF, 1'b0}},
    '{3'd7, 1'b0, 32'sh0, '{32'shFFFF_FFFF, 32'sh0, 24'd0, 1'b1}}
  };

  logic clk_i;
  logic rst_ni;

  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [AddrW-1:0]   paddr;
  logic [BusW-1:0]    pwdata;
  wire  [BusW-1:0]    prdata;
  wire                pready;

  pidaw_in_if  in_ch ();
  pidaw_out_if out_ch ();

  pid_controller_antiwindup dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .in_ch_i  (in_ch),
    .out_ch_o (out_ch),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  // predictor state and its copy of the registers
  cfg_t                    ctl_cfg;
  logic signed [DataW-1:0] integ_sum;
  logic signed [DataW-1:0] last_err;

  logic signed [DataW-1:0] pending_drive [$];
  bit                      gaps_on;
  int                      sink_wait;
  int                      errors;
  int                      words_checked;
  int                      cfg_loads;
  int                      clears_sent;

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    #(10_000_000);
    $display("FAIL pid_controller_antiwindup");
    $finish;
  end

  // ---------------------------------------------------------------- predictor

  function automatic logic signed [DataW-1:0] clamp_data(input logic signed [63:0] v);
    if (v > 64'sd2147483647) return MaxVal;
    if (v < -64'sd2147483648) return MinVal;
    return v[DataW-1:0];
  endfunction

  function automatic logic signed [DataW-1:0] from_mag(input logic neg, input logic [63:0] m);
    if (neg) return (m >= 64'h8000_0000) ? MinVal : -$signed(m[DataW-1:0]);
    return (m > 64'h7FFF_FFFF) ? MaxVal : $signed(m[DataW-1:0]);
  endfunction

  function automatic logic [DataW-1:0] abs_val(input logic signed [DataW-1:0] v);
    logic [DataW-1:0] u;
    u = v;
    return u[DataW-1] ? (~u + 1'b1) : u;
  endfunction

  // a*b >> 16 on magnitudes (round toward zero), then saturate
  function automatic logic signed [DataW-1:0] qmul(input logic signed [63:0] a,
                                                   input logic signed [63:0] b);
    logic [63:0] ua;
    logic [63:0] ub;
    ua = a[63] ? -a : a;
    ub = b[63] ? -b : b;
    return from_mag(a[63] != b[63], (ua * ub) >> FracW);
  endfunction

  function automatic logic signed [DataW-1:0] qdiv(input logic signed [63:0] num,
                                                   input logic [TimeW-1:0] den);
    logic [63:0] un;
    un = num[63] ? -num : num;
    return from_mag(num[63], (un << FracW) / {40'd0, den});
  endfunction

  function automatic logic signed [DataW-1:0] drive_step(input sample_t s);
    logic signed [DataW-1:0] err;
    logic signed [DataW-1:0] deriv;
    logic signed [DataW-1:0] drv;
    logic signed [DataW-1:0] cand;
    logic signed [DataW-1:0] trial;
    logic signed [DataW-1:0] lim;
    logic [TimeW-1:0]        den;
    if (s.clear_integ) integ_sum = '0;
    err = clamp_data(s.setpoint - s.measured);
    den = (s.time_step > ctl_cfg.step_floor) ? s.time_step : ctl_cfg.step_floor;
    if (den == 0) den = 1;
    deriv = qdiv(clamp_data(err - last_err), den);
    last_err = err;
    drv = clamp_data(qmul(err, ctl_cfg.gain_prop) + qmul(deriv, ctl_cfg.gain_deriv));
    if (ctl_cfg.gain_integ > 0) begin
      cand  = clamp_data(integ_sum + qmul(err, s.time_step));
      trial = clamp_data(drv + qmul(cand, ctl_cfg.gain_integ));
      if ((ctl_cfg.drive_limit == 0 || abs_val(trial) <= ctl_cfg.drive_limit) &&
          abs_val(cand) <= ctl_cfg.integ_limit) begin
        integ_sum = cand;
      end
      drv = clamp_data(drv + qmul(integ_sum, ctl_cfg.gain_integ));
    end
    if (ctl_cfg.drive_limit != 0) begin
      lim = {1'b0, ctl_cfg.drive_limit};
      if (drv > lim) drv = lim;
      else if (drv < -lim) drv = -lim;
    end
    return drv;
  endfunction

  function automatic void note_write(input logic [2:0] idx, input logic [BusW-1:0] val);
    case (idx)
      REG_GAIN_PROP:   ctl_cfg.gain_prop   = val;
      REG_GAIN_INTEG:  ctl_cfg.gain_integ  = val;
      REG_GAIN_DERIV:  ctl_cfg.gain_deriv  = val;
      REG_INTEG_LIMIT: ctl_cfg.integ_limit = val[LimW-1:0];
      REG_DRIVE_LIMIT: ctl_cfg.drive_limit = val[LimW-1:0];
      REG_STEP_FLOOR:  ctl_cfg.step_floor  = val[TimeW-1:0];
      default: ;
    endcase
  endfunction

  // ---------------------------------------------------------------- random picks

  function automatic logic signed [DataW-1:0] pick_gain();
    case ($urandom_range(0, 9))
      0: return MinVal;
      1: return MaxVal;
      2: return '0;
      3: return $urandom;
      default: return int'($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000;
    endcase
  endfunction

  function automatic logic [LimW-1:0] pick_limit();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return 31'h7FFF_FFFF;
      2: return 31'h1;
      3: return 31'($urandom);
      default: return 31'($urandom_range(0, 32'h0040_0000));
    endcase
  endfunction

  function automatic cfg_t rand_cfg();
    cfg_t c;
    c.gain_prop   = pick_gain();
    c.gain_deriv  = pick_gain();
    case ($urandom_range(0, 9))
      0: c.gain_integ = 32'sh1;
      1: c.gain_integ = MaxVal;
      2: c.gain_integ = $urandom | 32'h8000_0000;   // negative: path off
      3: c.gain_integ = '0;
      default: c.gain_integ = $urandom_range(1, 32'h0002_0000);
    endcase
    c.integ_limit = pick_limit();
    c.drive_limit = pick_limit();
    case ($urandom_range(0, 6))
      0: c.step_floor = 24'd1;
      1: c.step_floor = 24'hFF_FFFF;
      2: c.step_floor = 24'd66;
      3: c.step_floor = 24'($urandom_range(1, 24'hFF_FFFF));
      default: c.step_floor = 24'($urandom_range(1, 4096));
    endcase
    return c;
  endfunction

  function automatic logic signed [DataW-1:0] noise_word();
    case ($urandom_range(0, 11))
      0: return MaxVal;
      1: return MinVal;
      2: return '0;
      3: return -32'sd1;
      default: return $urandom;
    endcase
  endfunction

  // ---------------------------------------------------------------- bus tasks

  task automatic reg_write(input logic [2:0] idx, input logic [BusW-1:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    note_write(idx, val);
    @(posedge clk_i);
  endtask

  // unused upper bits of the narrow registers get junk; the block must mask them
  task automatic load_config(input cfg_t c);
    reg_write(REG_GAIN_PROP, c.gain_prop);
    reg_write(REG_GAIN_INTEG, c.gain_integ);
    reg_write(REG_GAIN_DERIV, c.gain_deriv);
    reg_write(REG_INTEG_LIMIT, {1'($urandom), c.integ_limit});
    reg_write(REG_DRIVE_LIMIT, {1'($urandom), c.drive_limit});
    reg_write(REG_STEP_FLOOR, {8'($urandom), c.step_floor});
    reg_write(RegSpareLo, $urandom);
    reg_write(RegSpareHi, $urandom);
    cfg_loads++;
  endtask

  // drain: no new words until every drive word is back
  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    while (pending_drive.size() != 0) @(posedge clk_i);
    repeat (IdleCyc) @(posedge clk_i);
  endtask

  // valid stays high across back-to-back words; it drops for a gap or a drain
  task automatic send_sample(input sample_t s, input logic signed [DataW-1:0] want);
    int gap;
    gap = gaps_on ? $urandom_range(0, 3) : 0;
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_ch.valid       <= 1'b1;
    in_ch.setpoint    <= s.setpoint;
    in_ch.measured    <= s.measured;
    in_ch.time_step   <= s.time_step;
    in_ch.clear_integ <= s.clear_integ;
    pending_drive.push_back(want);
    if (s.clear_integ) clears_sent++;
    do @(posedge clk_i); while (!in_ch.ready);
  endtask

  // ---------------------------------------------------------------- drive sink

  always @(posedge clk_i) begin
    logic signed [DataW-1:0] want;
    if (!rst_ni) begin
      out_ch.ready <= 1'b0;
      sink_wait = 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        words_checked++;
        if (pending_drive.size() == 0) begin
          $display("%0t: drive word %h arrived with nothing expected", $time, out_ch.drive);
          errors++;
        end else begin
          want = pending_drive.pop_front();
          if (out_ch.drive !== want) begin
            $display("%0t: drive mismatch, expected %h, got %h", $time, want, out_ch.drive);
            errors++;
          end
        end
        sink_wait = gaps_on ? $urandom_range(0, 3) : 0;
      end else if (!out_ch.ready && sink_wait > 0) begin
        sink_wait--;
      end
      out_ch.ready <= (sink_wait == 0);
    end
  end

  // ---------------------------------------------------------------- stimulus

  initial begin
    sample_t                 s;
    logic signed [DataW-1:0] want;
    logic [2:0]              cur_cfg;
    int                      seg_left;
    int                      aim;
    int                      spread;
    int                      nominal;

    rst_ni            = 1'b0;
    in_ch.valid       = 1'b0;
    in_ch.setpoint    = '0;
    in_ch.measured    = '0;
    in_ch.time_step   = '0;
    in_ch.clear_integ = 1'b0;
    psel              = 1'b0;
    penable           = 1'b0;
    pwrite            = 1'b0;
    paddr             = '0;
    pwdata            = '0;
    gaps_on           = 1'b1;
    errors            = 0;
    words_checked     = 0;
    cfg_loads         = 0;
    clears_sent       = 0;
    ctl_cfg           = DirCfgs[0];
    integ_sum         = '0;
    last_err          = '0;

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    cur_cfg = 3'd0;
    for (int i = 0; i < NumRows; i++) begin
      if (DirRows[i].cfg_sel != cur_cfg) begin
        wait_idle();
        cur_cfg = DirRows[i].cfg_sel;
        load_config(DirCfgs[cur_cfg]);
      end
      s    = DirRows[i].smp;
      want = drive_step(s);
      if (DirRows[i].known) want = DirRows[i].drive;
      send_sample(s, want);
    end

    for (int ph = 0; ph < NumPhases; ph++) begin
      wait_idle();
      gaps_on = (ph % 3) != 2;
      load_config(rand_cfg());
      seg_left = 0;
      for (int n = 0; n < PhaseItems; n++) begin
        if (ph % 4 == 1 && n == PhaseItems / 2) wait_idle();
        // a segment holds one setpoint, noise spread and nominal step
        if (seg_left == 0) begin
          seg_left = $urandom_range(10, 60);
          aim      = int'($urandom_range(0, 32'h00C8_0000)) - 32'sh0064_0000;
          spread   = $urandom_range(1, 32'h0004_0000);
          nominal  = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 24'hFF_FFFF)
                                                 : $urandom_range(1, 24'h00_2000);
        end
        seg_left--;
        if ($urandom_range(0, 4) != 0) begin
          s.setpoint    = aim;
          s.measured    = aim + int'($urandom_range(0, 2 * spread)) - spread;
          s.time_step   = 24'(nominal + $urandom_range(0, nominal / 4));
          s.clear_integ = ($urandom_range(0, 39) == 0);
        end else begin
          s.setpoint    = noise_word();
          s.measured    = noise_word();
          s.time_step   = 24'($urandom);
          s.clear_integ = 1'($urandom);
        end
        send_sample(s, drive_step(s));
      end
    end

    wait_idle();
    repeat (SettleCyc) @(posedge clk_i);

    $display("%0d drive words checked across %0d register settings", words_checked,
             cfg_loads);
    $display("%0d words cleared the integral; %0d mismatches", clears_sent, errors);
    if (errors == 0) begin
      $display("PASS pid_controller_antiwindup");
    end else begin
      $display("FAIL pid_controller_antiwindup");
    end
    $finish;
  end

endmodule
